// ===== src/dhc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types and constants of the diverging heat-map colormap.
// ----------------------------------------------------------------------------
package dhc_pkg;

	localparam int DENS_W   = 32;
	localparam int LEVEL_W  = 16;
	localparam int DIFF_W   = DENS_W + 1;
	localparam int STOP_W   = 7;
	localparam int BAND_W   = 4;
	localparam int QUEUE_DEPTH = 4;

	// Register indexes on the configuration port (byte address / 4).
	localparam logic [1:0] REG_MIN  = 2'd0;
	localparam logic [1:0] REG_MEAN = 2'd1;
	localparam logic [1:0] REG_MAX  = 2'd2;

	// Highest stop level the table can produce, used as a sanity bound.
	localparam logic [LEVEL_W-1:0] LEVEL_PEAK = 16'd64881;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} channel_t;

	// One classified sample: band index k, band width d and offset u <= d.
	typedef struct packed {
		logic [BAND_W-1:0] k;
		logic [DIFF_W-1:0] d;
		logic [DIFF_W-1:0] u;
	} band_item_t;

	// Stop table in hundredths of full scale.
	function automatic logic [STOP_W-1:0] stop_level(channel_t ch, logic [BAND_W-1:0] idx);
		logic [STOP_W-1:0] r, g, b;
		begin
			case (idx)
				4'd0: begin r = 7'd33; g = 7'd19; b = 7'd2; end
				4'd1: begin r = 7'd55; g = 7'd32; b = 7'd4; end
				4'd2: begin r = 7'd75; g = 7'd51; b = 7'd18; end
				4'd3: begin r = 7'd87; g = 7'd76; b = 7'd49; end
				4'd4: begin r = 7'd96; g = 7'd91; b = 7'd76; end
				4'd5: begin r = 7'd99; g = 7'd96; b = 7'd89; end
				4'd6: begin r = 7'd78; g = 7'd92; b = 7'd90; end
				4'd7: begin r = 7'd50; g = 7'd80; b = 7'd76; end
				4'd8: begin r = 7'd21; g = 7'd59; b = 7'd56; end
				4'd9: begin r = 7'd0;  g = 7'd40; b = 7'd37; end
				4'd10: begin r = 7'd0; g = 7'd24; b = 7'd19; end
				default: begin r = 7'd0; g = 7'd0; b = 7'd0; end
			endcase
			case (ch)
				CH_RED:   stop_level = r;
				CH_GREEN: stop_level = g;
				CH_BLUE:  stop_level = b;
				default:  stop_level = '0;
			endcase
		end
	endfunction

endpackage

// ===== src/dhc_if.sv =====
// ----------------------------------------------------------------------------
// dhc_sample_if / dhc_color_if
// Valid/ready channels for density samples and RGB results.
// ----------------------------------------------------------------------------
interface dhc_sample_if;
	logic valid;
	logic ready;
	logic signed [dhc_pkg::DENS_W-1:0] density_sample;

	modport source (output valid, output density_sample, input ready);
	modport sink (input valid, input density_sample, output ready);
endinterface

interface dhc_color_if;
	logic valid;
	logic ready;
	logic [dhc_pkg::LEVEL_W-1:0] red_level;
	logic [dhc_pkg::LEVEL_W-1:0] green_level;
	logic [dhc_pkg::LEVEL_W-1:0] blue_level;

	modport source (output valid, output red_level, output green_level, output blue_level,
		input ready);
	modport sink (input valid, input red_level, input green_level, input blue_level,
		output ready);
endinterface

// ===== src/dhc_front.sv =====
// ----------------------------------------------------------------------------
// dhc_front
// Accepts samples, classifies them against min/mean/max and finds band k, u, d.
// ----------------------------------------------------------------------------
module dhc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic signed [dhc_pkg::DENS_W-1:0] density_minimum,
	input  logic signed [dhc_pkg::DENS_W-1:0] density_mean,
	input  logic signed [dhc_pkg::DENS_W-1:0] density_maximum,
	dhc_sample_if.sink sample,
	input  logic full,
	output logic push,
	output dhc_pkg::band_item_t item
);
	localparam int SPAN_W = dhc_pkg::DIFF_W + 3;

	typedef enum logic [1:0] {
		CLS_TOP,
		CLS_UPPER,
		CLS_LOWER,
		CLS_BOTTOM
	} class_t;

	logic adv;
	logic v_s1, v_s2, v_s3;
	class_t cls_s1, cls_s2;
	logic [dhc_pkg::DIFF_W-1:0] diff_s1, d_s1;
	logic [SPAN_W-1:0] span_s2, d1_s2, d2_s2, d3_s2, d4_s2;
	dhc_pkg::band_item_t item_s3;

	logic signed [dhc_pkg::DIFF_W-1:0] x_e, min_e, mean_e, max_e;
	class_t cls_c;
	logic [dhc_pkg::DIFF_W-1:0] diff_c, d_c;
	logic [SPAN_W:0] t1, t2, t3, t4;
	logic [2:0] kk;
	logic [SPAN_W-1:0] u_w;
	logic [dhc_pkg::BAND_W-1:0] k_c;
	dhc_pkg::band_item_t item_c;

	assign adv = !(v_s3 && full);
	assign sample.ready = adv;
	assign push = v_s3 && !full;
	assign item = item_s3;

	// Stage 1: compare and subtract against the configured densities.
	always_comb begin
		x_e = dhc_pkg::DIFF_W'(sample.density_sample);
		min_e = dhc_pkg::DIFF_W'(density_minimum);
		mean_e = dhc_pkg::DIFF_W'(density_mean);
		max_e = dhc_pkg::DIFF_W'(density_maximum);
		if (x_e > max_e) begin
			cls_c = CLS_TOP;
		end else if (x_e > mean_e) begin
			cls_c = CLS_UPPER;
		end else if (x_e > min_e) begin
			cls_c = CLS_LOWER;
		end else begin
			cls_c = CLS_BOTTOM;
		end
		if (cls_c == CLS_UPPER) begin
			diff_c = dhc_pkg::DIFF_W'(max_e - x_e);
			d_c = dhc_pkg::DIFF_W'(max_e - mean_e);
		end else begin
			diff_c = dhc_pkg::DIFF_W'(mean_e - x_e);
			d_c = dhc_pkg::DIFF_W'(mean_e - min_e);
		end
	end

	// Stage 3: the band index is the number of multiples of d not above the span, plus 5 below the mean.
	always_comb begin
		t1 = {1'b0, span_s2} - {1'b0, d1_s2};
		t2 = {1'b0, span_s2} - {1'b0, d2_s2};
		t3 = {1'b0, span_s2} - {1'b0, d3_s2};
		t4 = {1'b0, span_s2} - {1'b0, d4_s2};
		if (!t4[SPAN_W]) begin
			kk = 3'd4; u_w = t4[SPAN_W-1:0];
		end else if (!t3[SPAN_W]) begin
			kk = 3'd3; u_w = t3[SPAN_W-1:0];
		end else if (!t2[SPAN_W]) begin
			kk = 3'd2; u_w = t2[SPAN_W-1:0];
		end else if (!t1[SPAN_W]) begin
			kk = 3'd1; u_w = t1[SPAN_W-1:0];
		end else begin
			kk = 3'd0; u_w = span_s2;
		end
		if (cls_s2 == CLS_LOWER) begin
			k_c = dhc_pkg::BAND_W'(kk) + 4'd5;
			if (k_c > 4'd9) begin
				k_c = 4'd9;
			end
		end else begin
			k_c = dhc_pkg::BAND_W'(kk);
		end
		case (cls_s2)
			CLS_TOP: begin
				item_c.k = 4'd0; item_c.d = 33'd1; item_c.u = 33'd0;
			end
			CLS_BOTTOM: begin
				// u equal to d lands exactly on the last stop.
				item_c.k = 4'd9; item_c.d = 33'd1; item_c.u = 33'd1;
			end
			default: begin
				item_c.k = k_c;
				item_c.d = d1_s2[dhc_pkg::DIFF_W-1:0];
				item_c.u = u_w[dhc_pkg::DIFF_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1 <= cls_c;
			diff_s1 <= diff_c;
			d_s1 <= d_c;
			cls_s2 <= cls_s1;
			span_s2 <= SPAN_W'({diff_s1, 2'b00}) + SPAN_W'(diff_s1);
			d1_s2 <= SPAN_W'(d_s1);
			d2_s2 <= SPAN_W'({d_s1, 1'b0});
			d3_s2 <= SPAN_W'({d_s1, 1'b0}) + SPAN_W'(d_s1);
			d4_s2 <= SPAN_W'({d_s1, 2'b00});
			item_s3 <= item_c;
		end
	end
endmodule

// ===== src/dhc_queue.sv =====
// ----------------------------------------------------------------------------
// dhc_queue
// Short FIFO between the classifying front and the blending back.
// ----------------------------------------------------------------------------
module dhc_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dhc_pkg::band_item_t wr_item,
	output logic full,
	input  logic pop,
	output logic empty,
	output dhc_pkg::band_item_t rd_item
);
	localparam int PTR_W = $clog2(dhc_pkg::QUEUE_DEPTH);

	dhc_pkg::band_item_t mem_q [dhc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full = (count_q == (PTR_W+1)'(dhc_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end
endmodule

// ===== src/dhc_div.sv =====
// ----------------------------------------------------------------------------
// dhc_div
// Pipelined restoring divider, one quotient bit per stage, 16-bit quotient.
// ----------------------------------------------------------------------------
module dhc_div (
	input  logic clk,
	input  logic en,
	input  logic [57:0] num,
	input  logic [40:0] den,
	output logic [dhc_pkg::LEVEL_W-1:0] quo
);
	localparam int QW = dhc_pkg::LEVEL_W;

	logic [57:0] rem_q [QW+1];
	logic [40:0] den_q [QW+1];
	logic [QW-1:0] quo_q [QW+1];

	assign quo = quo_q[QW];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num;
			den_q[0] <= den;
			quo_q[0] <= '0;
		end
	end

	for (genvar t = 0; t < QW; t++) begin : g_stage
		logic [57:0] shifted;
		logic [58:0] diff;
		assign shifted = 58'(den_q[t]) << (QW - 1 - t);
		assign diff = {1'b0, rem_q[t]} - {1'b0, shifted};
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[t+1] <= den_q[t];
				if (!diff[58]) begin
					rem_q[t+1] <= diff[57:0];
					quo_q[t+1] <= quo_q[t] | (QW'(1) << (QW - 1 - t));
				end else begin
					rem_q[t+1] <= rem_q[t];
					quo_q[t+1] <= quo_q[t];
				end
			end
		end
	end
endmodule

// ===== src/dhc_back.sv =====
// ----------------------------------------------------------------------------
// dhc_back
// Blends adjacent stops per channel and divides to a rounded Q0.16 level.
// ----------------------------------------------------------------------------
module dhc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  dhc_pkg::band_item_t rd_item,
	output logic pop,
	dhc_color_if.source color
);
	localparam int DIV_STAGES = dhc_pkg::LEVEL_W + 1;

	logic adv;
	logic v_s4, v_s5;
	logic [DIV_STAGES-1:0] v_div_q;
	logic [39:0] dh_s4, dh_s5;
	logic [39:0] pa_s4 [3];
	logic signed [41:0] pb_s4 [3];
	logic [39:0] n_s5 [3];
	logic [dhc_pkg::LEVEL_W-1:0] level [3];

	assign adv = !v_div_q[DIV_STAGES-1] || color.ready;
	assign pop = adv && !empty;
	assign color.valid = v_div_q[DIV_STAGES-1];
	assign color.red_level = level[0];
	assign color.green_level = level[1];
	assign color.blue_level = level[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_div_q <= '0;
		end else if (adv) begin
			v_s4 <= pop;
			v_s5 <= v_s4;
			v_div_q <= {v_div_q[DIV_STAGES-2:0], v_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dh_s4 <= 40'(rd_item.d) * 40'd100;
			dh_s5 <= dh_s4;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [dhc_pkg::STOP_W-1:0] a, b;
		logic signed [7:0] step;
		logic signed [41:0] n_w;
		assign a = dhc_pkg::stop_level(dhc_pkg::channel_t'(c), rd_item.k);
		assign b = dhc_pkg::stop_level(dhc_pkg::channel_t'(c), rd_item.k + 1'b1);
		assign step = $signed({1'b0, b}) - $signed({1'b0, a});
		assign n_w = $signed({2'b00, pa_s4[c]}) + pb_s4[c];

		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s4[c] <= 40'(a) * 40'(rd_item.d);
				pb_s4[c] <= 42'(step * $signed({1'b0, rd_item.u}));
				n_s5[c] <= n_w[39:0];
			end
		end

		// level = floor((2*N*65536 + 100d) / (200d)), i.e. rounded half up.
		dhc_div u_div (
			.clk(clk),
			.en(adv),
			.num({n_s5[c][39:0], 17'b0} + 58'(dh_s5)),
			.den({dh_s5, 1'b0}),
			.quo(level[c])
		);
	end
endmodule

// ===== src/diverging_heatmap_colormap.sv =====
// ----------------------------------------------------------------------------
// diverging_heatmap_colormap
// Maps signed Q16.16 densities to RGB Q0.16 through an 11-stop diverging table.
// ----------------------------------------------------------------------------
// One sample is accepted per clock unless a full queue stalls the front:
// three front stages classify the sample and find its band, a four-entry
// queue decouples them from the back end, which spends two stages on the
// stop blend multiplies and 17 on a pipelined divider that yields one
// quotient bit per stage. Stalls on the output hold the back end only; the
// front keeps accepting until the queue is full. Configuration registers
// (minimum, mean, maximum at byte addresses 0, 4, 8) are to be written by
// the user only while idle; the block itself does not enforce this.
module diverging_heatmap_colormap (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	dhc_sample_if.sink sample,
	dhc_color_if.source color
);
	logic signed [dhc_pkg::DENS_W-1:0] density_minimum_q, density_mean_q, density_maximum_q;
	logic push, pop, full, empty;
	dhc_pkg::band_item_t wr_item, rd_item;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_minimum_q <= '0;
			density_mean_q <= '0;
			density_maximum_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				dhc_pkg::REG_MIN:  density_minimum_q <= pwdata;
				dhc_pkg::REG_MEAN: density_mean_q <= pwdata;
				dhc_pkg::REG_MAX:  density_maximum_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dhc_pkg::REG_MIN:  prdata = density_minimum_q;
			dhc_pkg::REG_MEAN: prdata = density_mean_q;
			dhc_pkg::REG_MAX:  prdata = density_maximum_q;
			default: prdata = '0;
		endcase
	end

	dhc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.density_minimum(density_minimum_q),
		.density_mean(density_mean_q),
		.density_maximum(density_maximum_q),
		.sample(sample),
		.full(full),
		.push(push),
		.item(wr_item)
	);

	dhc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(wr_item),
		.full(full),
		.pop(pop),
		.empty(empty),
		.rd_item(rd_item)
	);

	dhc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.rd_item(rd_item),
		.pop(pop),
		.color(color)
	);

	// The front only stalls when the queue cannot take its last stage.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> full)
		else $error("sample stalled while the queue had room");

	// A popped transaction never comes from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

	// Blended levels never exceed the brightest stop.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		color.valid |-> (color.red_level <= dhc_pkg::LEVEL_PEAK &&
			color.green_level <= dhc_pkg::LEVEL_PEAK && color.blue_level <= dhc_pkg::LEVEL_PEAK))
		else $error("colour level above table peak");
endmodule
